>>> hdl/mbp_pkg.sv
`default_nettype none
package mbp_pkg;

   localparam int VALUE_W     = 64;
   localparam int WIDTH_W     = 7;
   localparam int COUNT_W     = 32;
   localparam int BITS_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int ACC_W       = VALUE_W + BYTE_W;
   localparam int FILL_W      = $clog2(ACC_W);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int APB_DATA_W  = 32;
   localparam int APB_ADDR_W  = 3;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(8);
   localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(VALUE_W);

   typedef enum logic [0:0] {
      REG_VALUE_WIDTH = 1'b0
   } reg_index_type;

   // one packing job: value left-aligned so its first bit sits at the top
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [WIDTH_W-1:0] width;
      logic               last_item;
      logic [BITS_W-1:0]  total;
   } job_type;

endpackage
`default_nettype wire

>>> hdl/mbp_req_if.sv
`default_nettype none
interface mbp_req_if import mbp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               last_item;

   modport source(output valid, output value, output last_item, input ready);
   modport sink(input valid, input value, input last_item, output ready);
endinterface
`default_nettype wire

>>> hdl/mbp_rsp_if.sv
`default_nettype none
interface mbp_rsp_if import mbp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;
   logic [BITS_W-1:0] bits_written;

   modport source(output valid, output out_byte, output last_byte, output bits_written,
                  input ready);
   modport sink(input valid, input out_byte, input last_byte, input bits_written,
                output ready);
endinterface
`default_nettype wire

>>> hdl/mbp_front.sv
`default_nettype none
module mbp_front import mbp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mbp_req_if.sink                    req_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output      logic [APB_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      logic                  q_push,
   output      job_type               q_data,
   input  wire logic                  q_full
);

   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [WIDTH_W-1:0] n;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] sat;
   logic               reg_hit;
   logic               accept;

   assign pready  = 1'b1;
   assign reg_hit = (reg_index_type'(paddr[APB_ADDR_W-1]) == REG_VALUE_WIDTH);

   always_comb begin
      width_in = width_ff;
      if (psel && penable && pwrite && reg_hit) begin
         width_in = pwdata[WIDTH_W-1:0];
      end
      prdata = '0;
      if (reg_hit) begin
         prdata = {{(APB_DATA_W-WIDTH_W){1'b0}}, width_ff};
      end
   end

   // clamp width into 1..64
   always_comb begin
      if (width_ff == '0) begin
         n = WIDTH_W'(1);
      end else if (width_ff > MAX_WIDTH) begin
         n = MAX_WIDTH;
      end else begin
         n = width_ff;
      end
   end

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign q_push       = accept;

   assign sum = {1'b0, total_ff} + {{(COUNT_W+1-WIDTH_W){1'b0}}, n};
   assign sat = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];

   always_comb begin
      total_in = total_ff;
      if (accept) begin
         total_in = req_ch.last_item ? '0 : sat;
      end
   end

   always_comb begin
      q_data.value     = req_ch.value << (MAX_WIDTH - n);
      q_data.width     = n;
      q_data.last_item = req_ch.last_item;
      q_data.total     = BITS_W'(sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         total_ff <= '0;
      end else begin
         width_ff <= width_in;
         total_ff <= total_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/mbp_queue.sv
`default_nettype none
module mbp_queue import mbp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output      logic    full,
   output      logic    pop_valid,
   output      job_type pop_data,
   input  wire logic    pop
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/mbp_back.sv
`default_nettype none
module mbp_back import mbp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire job_type q_data,
   output      logic    q_pop,
   mbp_rsp_if.source    rsp_ch
);

   // acc holds fill bits left-aligned; everything below them stays zero
   logic [ACC_W-1:0]  acc_ff, acc_in, acc1;
   logic [FILL_W-1:0] fill_ff, fill_in, fill1;
   logic              lastf_ff, lastf_in, lastf1;
   logic [BITS_W-1:0] tot_ff, tot_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              lastb_ff, lastb_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              can_emit;
   logic              want_emit;
   logic              emit;
   logic              final_byte;
   logic              load;

   assign can_emit   = !valid_ff || rsp_ch.ready;
   assign want_emit  = (fill_ff >= FILL_W'(BYTE_W)) || (lastf_ff && fill_ff != '0);
   assign emit       = want_emit && can_emit;
   assign final_byte = lastf_ff && (fill_ff <= FILL_W'(BYTE_W));

   always_comb begin
      acc1   = acc_ff;
      fill1  = fill_ff;
      lastf1 = lastf_ff;
      if (emit) begin
         acc1   = acc_ff << BYTE_W;
         fill1  = (fill_ff >= FILL_W'(BYTE_W)) ? fill_ff - FILL_W'(BYTE_W) : '0;
         lastf1 = lastf_ff && !final_byte;
      end
   end

   // take the next job once fewer than a byte's worth of bits remain
   assign load  = q_valid && (fill1 < FILL_W'(BYTE_W)) && !lastf1;
   assign q_pop = load;

   always_comb begin
      acc_in   = acc1;
      fill_in  = fill1;
      lastf_in = lastf1;
      tot_in   = tot_ff;
      if (load) begin
         acc_in   = acc1 | ({q_data.value, {BYTE_W{1'b0}}} >> fill1[2:0]);
         fill_in  = fill1 + FILL_W'(q_data.width);
         lastf_in = q_data.last_item;
         tot_in   = q_data.total;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      lastb_in = lastb_ff;
      bits_in  = bits_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = acc_ff[ACC_W-1 -: BYTE_W];
         lastb_in = final_byte;
         bits_in  = final_byte ? tot_ff : '0;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.out_byte     = byte_ff;
   assign rsp_ch.last_byte    = lastb_ff;
   assign rsp_ch.bits_written = bits_ff;

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      lastb_ff <= lastb_in;
      bits_ff  <= bits_in;
      tot_ff   <= tot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         fill_ff  <= '0;
         lastf_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         fill_ff  <= fill_in;
         lastf_ff <= lastf_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/msb_first_bit_packer_top.sv
// An item's bytes reach rsp_ch through the queue, the bit accumulator and the output
// byte register. Throughput: one item per cycle while value_width is 8 or less and
// rsp_ch is ready; wider items are limited by the one-byte-per-cycle output register.
// A last item's partial byte is flushed zero-padded, and a four-entry queue sits
// between the front and the byte emitter.
// Reset (synchronous, active high) empties the queue and stream, value_width = 8.
`default_nettype none
module msb_first_bit_packer_top import mbp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mbp_req_if.sink                    req_ch,
   mbp_rsp_if.source                  rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output      logic [APB_DATA_W-1:0] prdata,
   output      logic                  pready
);

   logic    q_push;
   logic    q_full;
   job_type q_wdata;
   logic    q_valid;
   job_type q_rdata;
   logic    q_pop;

   mbp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .q_push  (q_push),
      .q_data  (q_wdata),
      .q_full  (q_full)
   );

   mbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_data  (q_rdata),
      .pop       (q_pop)
   );

   mbp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
`default_nettype wire

>>> hdl/mbp_checker.sv
`default_nettype none
module mbp_checker import mbp_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [BYTE_W-1:0]     rsp_byte,
   input wire logic                  rsp_last,
   input wire logic [BITS_W-1:0]     rsp_bits,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic [APB_ADDR_W-1:0] paddr,
   input wire logic [APB_DATA_W-1:0] pwdata,
   input wire logic [APB_DATA_W-1:0] prdata
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last)
         && $stable(rsp_bits))
      else $error("stalled result changed");

   a_bits_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_bits == '0)
      else $error("bit count on a non-final byte");

   a_width_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr[APB_ADDR_W-1] == 1'b0
      |=> prdata[WIDTH_W-1:0] == $past(pwdata[WIDTH_W-1:0]) || !(paddr[APB_ADDR_W-1] == 1'b0))
      else $error("value_width readback mismatch");

endmodule

bind msb_first_bit_packer_top mbp_checker u_mbp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_byte  (rsp_ch.out_byte),
   .rsp_last  (rsp_ch.last_byte),
   .rsp_bits  (rsp_ch.bits_written),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);
`default_nettype wire
